// ===== design/ggvc_pkg.sv =====
// Package for the go-to-goal velocity controller.
// Holds the pipeline payload type, fixed-point constants and the CORDIC arctangent table.
// Depends on nothing; used by go_to_goal_velocity_controller_top.
`default_nettype none

package ggvc_pkg;

    // Angles in Q3.13 and Q6.26.
    localparam logic signed [17:0] PI_Q13         = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13     = 18'sd51472;
    localparam logic        [15:0] QUARTER_PI_Q13 = 16'd6434;
    localparam logic signed [31:0] PI_Q26         = 32'sd210828714;
    localparam logic signed [31:0] BEARING_ROUND  = 32'sd4096;

    // Square root iterations: the sum of squares is below 2^61.
    localparam int SQ_STEPS  = 31;
    localparam int SQ_WIDTH  = 61;
    localparam int CD_WIDTH  = 36;
    localparam int ATAN_LEN  = 24;

    // Register indexes on the configuration port.
    localparam logic REG_MAX_LINEAR = 1'b0;
    localparam logic REG_MAX_TURN   = 1'b1;

    // Action codes.
    localparam logic ACT_MOVE   = 1'b0;
    localparam logic ACT_ROTATE = 1'b1;

    localparam logic signed [31:0] ATAN_Q26 [ATAN_LEN] = '{
        32'sd52707179, 32'sd31114864, 32'sd16440240, 32'sd8345322,
        32'sd4188855,  32'sd2096470,  32'sd1048491,  32'sd524277,
        32'sd262143,   32'sd131072,   32'sd65536,    32'sd32768,
        32'sd16384,    32'sd8192,     32'sd4096,     32'sd2048,
        32'sd1024,     32'sd512,      32'sd256,      32'sd128,
        32'sd64,       32'sd32,       32'sd16,       32'sd8
    };

    // Payload carried by every pipeline stage; each stage fills in its own part.
    typedef struct packed {
        logic                        action;
        logic signed [15:0]          cur_yaw;
        logic signed [15:0]          tgt_yaw;
        logic        [15:0]          tol;
        logic signed [32:0]          dx;
        logic signed [32:0]          dy;
        logic                        far;
        logic        [59:0]          sq_x;
        logic        [59:0]          sq_y;
        logic        [31:0]          tol_sq;
        logic                        done_move;
        logic        [SQ_WIDTH-1:0]  rem;
        logic        [SQ_WIDTH-1:0]  root;
        logic signed [CD_WIDTH-1:0]  cx;
        logic signed [CD_WIDTH-1:0]  cy;
        logic signed [31:0]          cz;
        logic signed [15:0]          err;
        logic        [27:0]          lin_raw;
        logic        [14:0]          lin;
        logic signed [15:0]          ang;
        logic                        done;
    } pipe_t;

    // Wrap a heading error into [-pi, pi]; one correction suffices for the input range.
    function automatic logic signed [15:0] wrap_q13(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        if (a > PI_Q13) begin
            r = a - TWO_PI_Q13;
        end else if (a < -PI_Q13) begin
            r = a + TWO_PI_Q13;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/go_to_goal_velocity_controller_top.sv =====
// Top level of the go-to-goal velocity controller: a fully pipelined datapath.
// Depends on ggvc_pkg for the payload type, constants and the arctangent table.
`default_nettype none

// Usage
// One pose beat on the s_ channel yields one velocity beat on the m_ channel,
// in order. s_tuser carries the action (0 drive to point, 1 rotate to heading).
// Move mode measures the distance with a one-bit-per-stage square root and the
// bearing with a one-step-per-stage CORDIC in the first CORDIC_STEPS of those
// stages, then wraps the heading error and limits the speeds. Rotate mode only
// wraps and clamps the heading error.
// There are 36 register stages: entry, squares, sum, 31 square root stages,
// heading error, output. Throughput is one beat per cycle while m_tready
// does not hold the last stage, since every stage holds one beat.
// Valid bits travel with the data and each stage advances when its successor
// is free, so empty stages fill up even while m_tready is low; a stalled
// result holds in the last stage and nothing is lost or repeated.
// Reset clears all valid bits and loads the speed limits with 819 and 2048.
// The limits are written through the APB port at byte addresses 0 and 4; the user
// must write them only while the pipeline is empty, as the block does not enforce it.
module go_to_goal_velocity_controller_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input beats.
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // current_x, current_y, current_yaw, goal_x, goal_y, target heading, tolerance
    input  wire logic [175:0] s_tdata,
    // action
    input  wire logic [0:0]   s_tuser,
    // Result beats.
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // linear_velocity, angular_velocity, zero pad
    output      logic [31:0]  m_tdata,
    // done_res
    output      logic [0:0]   m_tuser,
    // Configuration.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output      logic [31:0]  prdata,
    output      logic         pready
);

    localparam int FIRST_SQ = 3;
    localparam int LAST     = FIRST_SQ + ggvc_pkg::SQ_STEPS + 1;
    localparam int DEPTH    = LAST + 1;

    ggvc_pkg::pipe_t stage_reg  [DEPTH];
    ggvc_pkg::pipe_t stage_next [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH:0]   adv;
    logic [14:0]      max_lin_reg;
    logic [14:0]      max_turn_reg;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lin_reg  <= 15'd819;
            max_turn_reg <= 15'd2048;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                ggvc_pkg::REG_MAX_LINEAR: max_lin_reg  <= pwdata[14:0];
                ggvc_pkg::REG_MAX_TURN:   max_turn_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ggvc_pkg::REG_MAX_LINEAR: prdata = {17'd0, max_lin_reg};
            ggvc_pkg::REG_MAX_TURN:   prdata = {17'd0, max_turn_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // A stage can load when it is empty or its own beat moves on.
    always_comb begin
        adv[DEPTH] = m_tready;
        for (int j = DEPTH - 1; j >= 0; j--) begin
            adv[j] = !valid_reg[j] || adv[j+1];
        end
    end
    assign s_tready = adv[0];

    // Stage logic.
    always_comb begin
        ggvc_pkg::pipe_t            p;
        logic signed [32:0]         ax_s;
        logic signed [32:0]         ay_s;
        logic        [61:0]         sbit;
        logic        [61:0]         trial;
        logic signed [ggvc_pkg::CD_WIDTH-1:0] ncx;
        logic signed [ggvc_pkg::CD_WIDTH-1:0] ncy;
        logic signed [31:0]         bz;
        logic signed [17:0]         diff;
        logic        [32:0]         dist3;
        logic        [15:0]         aerr;
        logic signed [16:0]         lim;
        int                         k;

        // Scratch values start from zero in every pass.
        ax_s  = '0;
        ay_s  = '0;
        sbit  = '0;
        trial = '0;
        ncx   = '0;
        ncy   = '0;
        bz    = '0;
        diff  = '0;
        dist3 = '0;
        aerr  = '0;
        lim   = '0;
        k     = 0;

        // Entry stage: unpack the beat and form the offsets.
        p          = stage_reg[0];
        p.action   = s_tuser[0];
        p.cur_yaw  = s_tdata[79:64];
        p.tgt_yaw  = s_tdata[159:144];
        p.tol      = s_tdata[175:160];
        p.dx       = {s_tdata[111], s_tdata[111:80]} - {s_tdata[31], s_tdata[31:0]};
        p.dy       = {s_tdata[143], s_tdata[143:112]} - {s_tdata[63], s_tdata[63:32]};
        stage_next[0] = p;

        for (int j = 1; j < DEPTH; j++) begin
            p = stage_reg[j-1];
            k = j - FIRST_SQ;
            if (j == 1) begin
                // Magnitudes, squares and the CORDIC half-plane fold.
                ax_s     = p.dx[32] ? -p.dx : p.dx;
                ay_s     = p.dy[32] ? -p.dy : p.dy;
                p.far    = (ax_s[32:30] != 3'd0) || (ay_s[32:30] != 3'd0);
                p.sq_x   = 60'(ax_s[29:0]) * 60'(ax_s[29:0]);
                p.sq_y   = 60'(ay_s[29:0]) * 60'(ay_s[29:0]);
                p.tol_sq = 32'(p.tol) * 32'(p.tol);
                if (p.dx[32]) begin
                    p.cx = -ggvc_pkg::CD_WIDTH'(p.dx);
                    p.cy = -ggvc_pkg::CD_WIDTH'(p.dy);
                    p.cz = p.dy[32] ? -ggvc_pkg::PI_Q26 : ggvc_pkg::PI_Q26;
                end else begin
                    p.cx = ggvc_pkg::CD_WIDTH'(p.dx);
                    p.cy = ggvc_pkg::CD_WIDTH'(p.dy);
                    p.cz = 32'sd0;
                end
            end else if (j == 2) begin
                // Sum of squares and the exact done test.
                p.rem       = 61'(p.sq_x) + 61'(p.sq_y);
                p.root      = '0;
                p.done_move = !p.far && (p.rem <= 61'(p.tol_sq));
            end else if (j < FIRST_SQ + ggvc_pkg::SQ_STEPS) begin
                // One square root digit per stage; the first CORDIC_STEPS stages also rotate once.
                sbit  = 62'(1) << (60 - 2 * k);
                trial = {1'b0, p.root} + sbit;
                if ({1'b0, p.rem} >= trial) begin
                    p.rem  = p.rem - trial[60:0];
                    p.root = (p.root >> 1) + sbit[60:0];
                end else begin
                    p.root = p.root >> 1;
                end
                if (k < CORDIC_STEPS) begin
                    if (p.cy > 0) begin
                        ncx  = p.cx + (p.cy >>> k);
                        ncy  = p.cy - (p.cx >>> k);
                        p.cz = p.cz + ggvc_pkg::ATAN_Q26[5'(k)];
                    end else begin
                        ncx  = p.cx - (p.cy >>> k);
                        ncy  = p.cy + (p.cx >>> k);
                        p.cz = p.cz - ggvc_pkg::ATAN_Q26[5'(k)];
                    end
                    p.cx = ncx;
                    p.cy = ncy;
                end
            end else if (j == LAST - 1) begin
                // Heading error and the distance-based speed.
                bz = p.cz + ggvc_pkg::BEARING_ROUND;
                if (p.action == ggvc_pkg::ACT_MOVE) begin
                    diff = bz[30:13] - 18'(p.cur_yaw);
                end else begin
                    diff = 18'(p.tgt_yaw) - 18'(p.cur_yaw);
                end
                p.err     = ggvc_pkg::wrap_q13(diff);
                dist3     = 33'(p.root[30:0]) * 33'd3;
                p.lin_raw = dist3[32:5];
            end else begin
                // Output stage: done flag, limits and clamps.
                aerr  = p.err[15] ? 16'(-p.err) : 16'(p.err);
                lim   = 17'(max_turn_reg);
                p.lin = 15'd0;
                p.ang = 16'sd0;
                if (p.action == ggvc_pkg::ACT_MOVE) begin
                    p.done = p.done_move;
                    if (!p.done_move) begin
                        if (p.far || (p.lin_raw >= 28'(max_lin_reg))) begin
                            p.lin = max_lin_reg;
                        end else begin
                            p.lin = p.lin_raw[14:0];
                        end
                        if (aerr > ggvc_pkg::QUARTER_PI_Q13) begin
                            p.lin = 15'd0;
                        end
                        p.ang = p.err;
                    end
                end else begin
                    p.done = ({aerr, 3'b000} <= 19'(p.tol));
                    if (!p.done) begin
                        if (17'(p.err) > lim) begin
                            p.ang = 16'(lim);
                        end else if (17'(p.err) < -lim) begin
                            p.ang = 16'(-lim);
                        end else begin
                            p.ang = p.err;
                        end
                    end
                end
            end
            stage_next[j] = p;
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int j = 1; j < DEPTH; j++) begin
                if (adv[j]) begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        for (int j = 0; j < DEPTH; j++) begin
            if (adv[j]) begin
                stage_reg[j] <= stage_next[j];
            end
        end
    end

    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = {1'b0, stage_reg[LAST].ang, stage_reg[LAST].lin};
    assign m_tuser  = stage_reg[LAST].done;

    // A finished beat carries no motion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && stage_reg[LAST].done |-> (m_tdata[30:0] == 31'd0))
        else $error("done beat with nonzero velocity");

    // Rotate mode never drives forward.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stage_reg[LAST].action == ggvc_pkg::ACT_ROTATE)
            |-> (stage_reg[LAST].lin == 15'd0))
        else $error("forward speed in rotate mode");

    // An empty output stage never blocks the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[LAST] |-> s_tready)
        else $error("input stalled with free output stage");

    // Forward speed never exceeds the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (stage_reg[LAST].lin <= max_lin_reg))
        else $error("forward speed above limit");

endmodule

`default_nettype wire
